/* hdl/lpad_pkg.sv */
// Package for the length-prefixed Adler-32 deframer.
// Holds the section and status codes, the result beat type and shared constants.
// No dependencies.
package lpad_pkg;

  // Section tags; the parser phase uses the first five.
  typedef enum logic [2:0] {
    SEC_LEN  = 3'd0,
    SEC_NLEN = 3'd1,
    SEC_NAME = 3'd2,
    SEC_PAY  = 3'd3,
    SEC_CSUM = 3'd4,
    SEC_HALT = 3'd5
  } sect_t;

  // End-of-frame status codes.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CSUM = 2'd1,
    ST_NAME = 2'd2,
    ST_LEN  = 2'd3
  } stat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    sect_t      section;
    logic       report;
    stat_t      status;
  } out_beat_t;

  localparam int          FIELD_BYTES = 4;      // bytes in each fixed field
  localparam int          HDR_BYTES   = 8;      // name-length field plus checksum
  localparam logic [16:0] ADLER_MOD   = 17'd65521;
  localparam logic [16:0] MIN_LEN_RST = 17'd10;
  localparam int          CFG_W       = 17;

endpackage

/* hdl/lpad_if.sv */
// Channel interfaces for the deframer: byte input and tagged result output.
// Depends on lpad_pkg.
interface lpad_in_if import lpad_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lpad_out_if import lpad_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  sect_t      section;
  logic       report;
  stat_t      status;

  modport source (output valid, output out_byte, output section, output report,
                  output status, input ready);
  modport sink (input valid, input out_byte, input section, input report,
                input status, output ready);
endinterface

/* hdl/lpad_adler.sv */
// Single-byte Adler-32 update of the low and high sums.
// Depends on lpad_pkg for the modulus.
module lpad_adler import lpad_pkg::*; (
  input  logic [15:0] sum_lo,
  input  logic [15:0] sum_hi,
  input  logic [7:0]  data,
  output logic [15:0] sum_lo_nxt,
  output logic [15:0] sum_hi_nxt
);

  logic [16:0] lo_raw;
  logic [16:0] lo_mod;
  logic [16:0] hi_raw;
  logic [16:0] hi_mod;

  // Low += byte, high += new low; fold both once (all operands < modulus).
  always_comb begin
    lo_raw = {1'b0, sum_lo} + {9'b0, data};
    lo_mod = (lo_raw >= ADLER_MOD) ? (lo_raw - ADLER_MOD) : lo_raw;
    hi_raw = {1'b0, sum_hi} + lo_mod;
    hi_mod = (hi_raw >= ADLER_MOD) ? (hi_raw - ADLER_MOD) : hi_raw;
  end

  assign sum_lo_nxt = lo_mod[15:0];
  assign sum_hi_nxt = hi_mod[15:0];

endmodule

/* hdl/lpad_parser.sv */
// Frame parser: section tracking, length checks, checksum compare and halt.
// Depends on lpad_pkg and lpad_adler.
module lpad_parser import lpad_pkg::*; #(
  parameter int MAX_FRAME_LEN = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [7:0]       in_byte,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output out_beat_t        beat,
  output logic             halted
);

  localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);

  sect_t             phase_r, phase_nxt;
  logic              halted_r, halted_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       frame_len_r, frame_len_nxt;
  logic [31:0]       name_len_r, name_len_nxt;
  logic [LEN_W-1:0]  room_r, room_nxt;
  logic [LEN_W-1:0]  name_span_r, name_span_nxt;
  logic [LEN_W-1:0]  pay_span_r, pay_span_nxt;
  logic              bad_name_r, bad_name_nxt;
  logic [15:0]       sum_lo_r, sum_lo_nxt;
  logic [15:0]       sum_hi_r, sum_hi_nxt;
  logic [31:0]       rx_csum_r, rx_csum_nxt;
  logic [CFG_W-1:0]  min_len_r;

  logic [15:0]       add_lo;
  logic [15:0]       add_hi;
  logic [31:0]       fl_shift;
  logic [31:0]       nl_shift;
  logic [31:0]       rx_shift;
  logic [LEN_W-1:0]  cnt_inc;
  logic [LEN_W-1:0]  span;
  logic              field_last;

  lpad_adler u_adler (
    .sum_lo     (sum_lo_r),
    .sum_hi     (sum_hi_r),
    .data       (in_byte),
    .sum_lo_nxt (add_lo),
    .sum_hi_nxt (add_hi)
  );

  assign fl_shift   = {frame_len_r[23:0], in_byte};
  assign nl_shift   = {name_len_r[23:0], in_byte};
  assign rx_shift   = {rx_csum_r[23:0], in_byte};
  assign cnt_inc    = cnt_r + LEN_W'(1);
  assign field_last = (cnt_r == LEN_W'(FIELD_BYTES - 1));
  assign span       = (nl_shift < 32'(room_r)) ? nl_shift[LEN_W-1:0] : room_r;
  assign halted     = halted_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= MIN_LEN_RST;
    end else if (cfg_we) begin
      min_len_r <= cfg_wdata;
    end
  end

  // State registers, updated on each accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= SEC_LEN;
      halted_r    <= 1'b0;
      cnt_r       <= '0;
      frame_len_r <= '0;
      name_len_r  <= '0;
      room_r      <= '0;
      name_span_r <= '0;
      pay_span_r  <= '0;
      bad_name_r  <= 1'b0;
      sum_lo_r    <= 16'd1;
      sum_hi_r    <= '0;
      rx_csum_r   <= '0;
    end else if (take) begin
      phase_r     <= phase_nxt;
      halted_r    <= halted_nxt;
      cnt_r       <= cnt_nxt;
      frame_len_r <= frame_len_nxt;
      name_len_r  <= name_len_nxt;
      room_r      <= room_nxt;
      name_span_r <= name_span_nxt;
      pay_span_r  <= pay_span_nxt;
      bad_name_r  <= bad_name_nxt;
      sum_lo_r    <= sum_lo_nxt;
      sum_hi_r    <= sum_hi_nxt;
      rx_csum_r   <= rx_csum_nxt;
    end
  end

  // Next state and the result beat for the current byte.
  always_comb begin
    phase_nxt     = phase_r;
    halted_nxt    = halted_r;
    cnt_nxt       = cnt_r;
    frame_len_nxt = frame_len_r;
    name_len_nxt  = name_len_r;
    room_nxt      = room_r;
    name_span_nxt = name_span_r;
    pay_span_nxt  = pay_span_r;
    bad_name_nxt  = bad_name_r;
    sum_lo_nxt    = sum_lo_r;
    sum_hi_nxt    = sum_hi_r;
    rx_csum_nxt   = rx_csum_r;

    beat.out_byte = in_byte;
    beat.section  = phase_r;
    beat.report   = 1'b0;
    beat.status   = ST_OK;

    if (halted_r) begin
      beat.section = SEC_HALT;
    end else begin
      case (phase_r)
        SEC_LEN: begin
          frame_len_nxt = fl_shift;
          cnt_nxt       = cnt_inc;
          if (field_last) begin
            cnt_nxt = '0;
            if ((fl_shift < 32'(HDR_BYTES)) || (fl_shift < 32'(min_len_r)) ||
                (fl_shift > 32'(MAX_FRAME_LEN))) begin
              beat.report = 1'b1;
              beat.status = ST_LEN;
              halted_nxt  = 1'b1;
            end else begin
              phase_nxt = SEC_NLEN;
              room_nxt  = fl_shift[LEN_W-1:0] - LEN_W'(HDR_BYTES);
            end
          end
        end
        SEC_NLEN: begin
          sum_lo_nxt   = add_lo;
          sum_hi_nxt   = add_hi;
          name_len_nxt = nl_shift;
          cnt_nxt      = cnt_inc;
          if (field_last) begin
            cnt_nxt       = '0;
            name_span_nxt = span;
            pay_span_nxt  = room_r - span;
            bad_name_nxt  = (nl_shift < 32'd2) || (nl_shift > 32'(room_r));
            if (span != '0) begin
              phase_nxt = SEC_NAME;
            end else if (room_r != span) begin
              phase_nxt = SEC_PAY;
            end else begin
              phase_nxt = SEC_CSUM;
            end
          end
        end
        SEC_NAME: begin
          sum_lo_nxt = add_lo;
          sum_hi_nxt = add_hi;
          cnt_nxt    = cnt_inc;
          if (cnt_inc == name_span_r) begin
            cnt_nxt   = '0;
            phase_nxt = (pay_span_r != '0) ? SEC_PAY : SEC_CSUM;
          end
        end
        SEC_PAY: begin
          sum_lo_nxt = add_lo;
          sum_hi_nxt = add_hi;
          cnt_nxt    = cnt_inc;
          if (cnt_inc == pay_span_r) begin
            cnt_nxt   = '0;
            phase_nxt = SEC_CSUM;
          end
        end
        default: begin
          rx_csum_nxt = rx_shift;
          cnt_nxt     = cnt_inc;
          if (field_last) begin
            beat.report = 1'b1;
            if ({sum_hi_r, sum_lo_r} != rx_shift) begin
              beat.status = ST_CSUM;
              halted_nxt  = 1'b1;
            end else if (bad_name_r) begin
              beat.status = ST_NAME;
              halted_nxt  = 1'b1;
            end else begin
              // Good frame: start over on the next byte.
              phase_nxt     = SEC_LEN;
              cnt_nxt       = '0;
              frame_len_nxt = '0;
              name_len_nxt  = '0;
              sum_lo_nxt    = 16'd1;
              sum_hi_nxt    = '0;
              rx_csum_nxt   = '0;
            end
          end
        end
      endcase
    end
  end

endmodule

/* hdl/lpad_obuf.sv */
// Two-beat output buffer that decouples the parser from the result channel.
// Depends on lpad_pkg and lpad_out_if.
module lpad_obuf import lpad_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  out_beat_t         push_beat,
  output logic              can_push,
  lpad_out_if.source        out_bus
);

  out_beat_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;
  out_beat_t  head;

  assign pop      = out_bus.valid && out_bus.ready;
  assign can_push = (count_r != 2'd2);
  assign head     = slot_r[rd_ptr_r];

  // Beat storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_beat;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Result channel drive.
  assign out_bus.valid    = (count_r != 2'd0);
  assign out_bus.out_byte = head.out_byte;
  assign out_bus.section  = head.section;
  assign out_bus.report   = head.report;
  assign out_bus.status   = head.status;

endmodule

/* hdl/length_prefixed_adler32_deframer.sv */
// Length-prefixed Adler-32 deframer, top level.
// Throughput: one byte per cycle while the output buffer has room; each byte
// is parsed in the cycle it is taken and its result registered into the buffer.
// A two-beat output buffer cuts the combinational path from output to input ready.
// Reset (synchronous, active low) initialises all parser state, sets min_frame_len
// to 10 and empties the buffer; an error halts the block until the next reset.
module length_prefixed_adler32_deframer import lpad_pkg::*; #(
  parameter int MAX_FRAME_LEN = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  lpad_in_if.sink          in_bus,
  lpad_out_if.source       out_bus,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  out_beat_t beat;
  logic      halted;
  logic      can_push;
  logic      take;

  assign in_bus.ready = can_push;
  assign take         = in_bus.valid && can_push;

  lpad_parser #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_bus.in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .beat      (beat),
    .halted    (halted)
  );

  lpad_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_beat (beat),
    .can_push  (can_push),
    .out_bus   (out_bus)
  );

  // Once halted, only reset releases the block.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted |=> halted)
    else $error("halt released without reset");

  // While halted, every beat is tagged discarded and carries no report.
  a_halt_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (take && halted) |-> (beat.section == SEC_HALT && !beat.report))
    else $error("beat not tagged discarded while halted");

  // A report appears only on a length or checksum byte.
  a_report_place: assert property (@(posedge clk) disable iff (!rst_n)
    (take && beat.report) |-> (beat.section == SEC_LEN || beat.section == SEC_CSUM))
    else $error("report outside length or checksum section");

  // A non-ok report halts the block on the following cycle.
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (take && beat.report && beat.status != ST_OK) |=> halted)
    else $error("error report did not halt the block");

endmodule

/* verif/deframer_tb_pkg.sv */
`timescale 1ns / 1ps
// Testbench package for the length-prefixed Adler-32 deframer: stimulus codes,
// a checksum helper and the tracker class that predicts and checks result beats.
// Depends on lpad_pkg.
package deframer_tb_pkg;
  import lpad_pkg::*;

  localparam int unsigned FRAME_LEN_MAX = 65536;
  localparam logic [31:0] ADLER_START   = 32'h0000_0001;
  localparam int unsigned NAME_LEN_MIN  = 2;
  localparam int          MAX_PRINTED   = 30;

  // How often a side inserts idle cycles between beats.
  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_SPARSE} pace_t;

  // Content of the name and payload bytes of a generated frame.
  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_EDGE} fill_t;

  // Ways of ending the stream with an error that halts the block.
  typedef enum int {
    BREAK_CSUM,
    BREAK_NAME_SHORT,
    BREAK_NAME_LONG,
    BREAK_LEN_SHORT,
    BREAK_LEN_LONG,
    BREAK_TINY_MIN,
    BREAK_BOTH
  } break_t;

  // One Adler-32 byte update; the sums are packed as {high, low}.
  function automatic logic [31:0] adler_fold(logic [31:0] sums, logic [7:0] b);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = {1'b0, sums[15:0]} + b;
    if (lo >= ADLER_MOD) lo = lo - ADLER_MOD;
    hi = {1'b0, sums[31:16]} + lo;
    if (hi >= ADLER_MOD) hi = hi - ADLER_MOD;
    return {hi[15:0], lo[15:0]};
  endfunction

  // Tracks the parser state, predicts the beat for every accepted byte and
  // checks the result beats in order.
  class deframer_tracker;
    out_beat_t   expected_beats[$];
    int unsigned mismatches;
    logic [16:0] min_len;
    sect_t       stage;
    logic [31:0] count;
    logic [31:0] flen;
    logic [31:0] nlen;
    logic [31:0] rx_csum;
    logic [31:0] sums;
    bit          halted;

    function new();
      mismatches = 0;
      power_on();
    endfunction

    function void power_on();
      min_len = MIN_LEN_RST;
      halted  = 1'b0;
      expected_beats.delete();
      restart();
    endfunction

    function void restart();
      stage   = SEC_LEN;
      count   = '0;
      flen    = '0;
      nlen    = '0;
      rx_csum = '0;
      sums    = ADLER_START;
    endfunction

    function void set_min_len(logic [16:0] v);
      min_len = v;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // The name never runs past the space left before the checksum.
    function logic [31:0] name_span();
      logic [31:0] room;
      room = flen - HDR_BYTES;
      return (nlen < room) ? nlen : room;
    endfunction

    function logic [31:0] payload_span();
      return flen - HDR_BYTES - name_span();
    endfunction

    function void enter_body();
      count = '0;
      stage = (payload_span() != 0) ? SEC_PAY : SEC_CSUM;
    endfunction

    function out_beat_t predict_beat(logic [7:0] b);
      out_beat_t beat;
      beat.out_byte = b;
      beat.section  = halted ? SEC_HALT : stage;
      beat.report   = 1'b0;
      beat.status   = ST_OK;
      if (!halted) begin
        case (stage)
          // Frame length: judged on its last byte.
          SEC_LEN: begin
            flen = {flen[23:0], b};
            count++;
            if (count == FIELD_BYTES) begin
              count = '0;
              if (flen < HDR_BYTES || flen < min_len || flen > FRAME_LEN_MAX) begin
                beat.report = 1'b1;
                beat.status = ST_LEN;
                halted      = 1'b1;
              end else begin
                stage = SEC_NLEN;
              end
            end
          end
          SEC_NLEN: begin
            sums = adler_fold(sums, b);
            nlen = {nlen[23:0], b};
            count++;
            if (count == FIELD_BYTES) begin
              count = '0;
              if (name_span() != 0) stage = SEC_NAME;
              else enter_body();
            end
          end
          SEC_NAME: begin
            sums = adler_fold(sums, b);
            count++;
            if (count >= name_span()) enter_body();
          end
          SEC_PAY: begin
            sums = adler_fold(sums, b);
            count++;
            if (count >= payload_span()) begin
              count = '0;
              stage = SEC_CSUM;
            end
          end
          // Checksum: the checksum is tested before the name length.
          default: begin
            rx_csum = {rx_csum[23:0], b};
            count++;
            if (count >= FIELD_BYTES) begin
              beat.report = 1'b1;
              if (sums != rx_csum) begin
                beat.status = ST_CSUM;
                halted      = 1'b1;
              end else if (nlen < NAME_LEN_MIN || nlen > flen - HDR_BYTES) begin
                beat.status = ST_NAME;
                halted      = 1'b1;
              end else begin
                beat.status = ST_OK;
                restart();
              end
            end
          end
        endcase
      end
      return beat;
    endfunction

    function void take_byte(logic [7:0] b);
      expected_beats.push_back(predict_beat(b));
    endfunction

    task log_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("MISMATCH: %s", msg);
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        log_mismatch($sformatf("beat with nothing pending: byte %02h section %0d",
                               got.out_byte, got.section));
        return;
      end
      want = expected_beats.pop_front();
      if (got.out_byte !== want.out_byte)
        log_mismatch($sformatf("out_byte %02h, wanted %02h", got.out_byte, want.out_byte));
      if (got.section !== want.section)
        log_mismatch($sformatf("section %0d, wanted %0d (byte %02h)",
                               got.section, want.section, want.out_byte));
      if (got.report !== want.report)
        log_mismatch($sformatf("report %0b, wanted %0b (byte %02h)",
                               got.report, want.report, want.out_byte));
      if (got.status !== want.status)
        log_mismatch($sformatf("status %0d, wanted %0d (byte %02h)",
                               got.status, want.status, want.out_byte));
    endtask
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Top-level testbench for length_prefixed_adler32_deframer: builds checksummed
// frames, drives them with random pacing and checks every tagged result beat.
// Depends on lpad_pkg, lpad_if, deframer_tb_pkg and the deframer RTL.
module tb_top;
  import lpad_pkg::*;
  import deframer_tb_pkg::*;

  localparam int RANDOM_BYTES  = 2000;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_BASE     = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int NOISE_BYTES   = 40;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lpad_in_if  in_bus ();
  lpad_out_if out_bus ();

  deframer_tracker tracker = new();

  pace_t       tx_pace;
  pace_t       rx_pace;
  bit          hold_pending;
  logic [16:0] min_setting;
  int          bytes_sent;
  int          cycles;

  length_prefixed_adler32_deframer #(.MAX_FRAME_LEN(FRAME_LEN_MAX)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit, far above the slowest legal run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Monitor: input beats and register writes feed the tracker, output beats
  // are checked against it, all in one process.
  always @(posedge clk) begin
    out_beat_t beat;
    if (!rst_n) begin
      tracker.power_on();
    end else begin
      if (in_bus.valid && in_bus.ready) tracker.take_byte(in_bus.in_byte);
      if (cfg_we) tracker.set_min_len(cfg_wdata);
      if (out_bus.valid && out_bus.ready) begin
        beat.out_byte = out_bus.out_byte;
        beat.section  = out_bus.section;
        beat.report   = out_bus.report;
        beat.status   = out_bus.status;
        tracker.check_beat(beat);
      end
    end
  end

  function automatic int draw_gap(pace_t pace);
    int gap;
    case (pace)
      PACE_FULL:   gap = 0;
      PACE_RANDOM: gap = $urandom_range(0, 9);
      default:     gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
    endcase
    return gap;
  endfunction

  function automatic logic [7:0] body_byte(fill_t fill, int unsigned idx);
    logic [7:0] b;
    case (fill)
      FILL_ONES:  b = 8'hFF;
      FILL_ZEROS: b = 8'h00;
      FILL_EDGE:  b = idx[0] ? 8'h00 : 8'hFF;
      default:    b = 8'($urandom_range(0, 255));
    endcase
    return b;
  endfunction

  // Offers one byte and returns at the falling edge after it was taken.
  // Valid stays high on return; the next call or wait_idle sets it.
  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap(tx_pace);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  // Sends a whole frame: length, name length, flen-8 body bytes and the
  // checksum, optionally with one checksum bit flipped.
  task automatic send_frame(logic [31:0] flen, logic [31:0] nlen, fill_t fill, bit spoil);
    logic [31:0] sums;
    logic [7:0]  b;
    sums = ADLER_START;
    send_word(flen);
    for (int i = 3; i >= 0; i--) begin
      b    = nlen[8*i +: 8];
      sums = adler_fold(sums, b);
      send_byte(b);
    end
    for (int unsigned k = HDR_BYTES; k < flen; k++) begin
      b    = body_byte(fill, k);
      sums = adler_fold(sums, b);
      send_byte(b);
    end
    if (spoil) sums = sums ^ (32'h1 << $urandom_range(0, 31));
    send_word(sums);
  endtask

  // Stops offering and waits until every pending result beat has come out.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_min_len(logic [16:0] v);
    min_setting = v;
    cfg_wdata  <= v;
    cfg_we     <= 1'b1;
    @(negedge clk);
    cfg_we     <= 1'b0;
  endtask

  // A well-formed frame with sizes biased toward the edges.
  task automatic random_frame();
    logic [31:0] flen;
    logic [31:0] nlen;
    fill_t       fill;
    case ($urandom_range(0, 7))
      0, 1:    flen = 32'(min_setting);
      2:       flen = min_setting + $urandom_range(0, 300);
      default: flen = min_setting + $urandom_range(0, 24);
    endcase
    case ($urandom_range(0, 3))
      0:       nlen = NAME_LEN_MIN;
      1:       nlen = flen - HDR_BYTES;
      default: nlen = $urandom_range(NAME_LEN_MIN, flen - HDR_BYTES);
    endcase
    case ($urandom_range(0, 7))
      0:       fill = FILL_ONES;
      1:       fill = FILL_ZEROS;
      2:       fill = FILL_EDGE;
      default: fill = FILL_RANDOM;
    endcase
    tx_pace = pace_t'($urandom_range(0, 2));
    rx_pace = pace_t'($urandom_range(0, 2));
    send_frame(flen, nlen, fill, 1'b0);
  endtask

  // Ends the stream with one error of a random kind, then sends bytes that
  // must all come back as discarded.
  task automatic break_stream();
    break_t      kind;
    logic [16:0] floor_len;
    logic [31:0] flen;
    logic [31:0] nlen;
    kind = break_t'($urandom_range(0, 6));
    wait_idle();
    case (kind)
      BREAK_LEN_SHORT: floor_len = 17'($urandom_range(11, 200));
      BREAK_TINY_MIN:  floor_len = 17'($urandom_range(0, 9));
      default:         floor_len = 17'($urandom_range(10, 40));
    endcase
    write_min_len(floor_len);
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
    flen    = floor_len + $urandom_range(0, 24);
    case (kind)
      BREAK_CSUM:
        send_frame(flen, $urandom_range(NAME_LEN_MIN, flen - HDR_BYTES), FILL_RANDOM, 1'b1);
      BREAK_NAME_SHORT:
        send_frame(flen, $urandom_range(0, 1), FILL_RANDOM, 1'b0);
      BREAK_NAME_LONG: begin
        // Either a length past the room left or one that is negative as int.
        nlen = $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                    : flen - HDR_BYTES + 1 + $urandom_range(0, 50);
        send_frame(flen, nlen, FILL_RANDOM, 1'b0);
      end
      BREAK_BOTH:
        send_frame(flen, $urandom_range(0, 1), FILL_RANDOM, 1'b1);
      BREAK_LEN_SHORT:
        send_word($urandom_range(HDR_BYTES, floor_len - 1));
      BREAK_LEN_LONG:
        send_word($urandom_range(0, 1) ? FRAME_LEN_MAX + 1
                                       : $urandom_range(FRAME_LEN_MAX + 1, 32'hFFFF_FFFF));
      default: begin
        // Minimum below the reset default: lengths under 8 still fail, and
        // a length of exactly 8 leaves no room for a valid name.
        flen = $urandom_range(0, HDR_BYTES);
        if (flen == HDR_BYTES) send_frame(flen, $urandom, FILL_RANDOM, 1'($urandom_range(0, 1)));
        else send_word(flen);
      end
    endcase
    for (int i = 0; i < NOISE_BYTES; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls per beat, plus a long hold-off on request.
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_gap(rx_pace);
      if (hold_pending) begin
        hold_pending = 1'b0;
        gap = HOLD_BASE + $urandom_range(0, 200);
      end
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      @(negedge clk);
    end
  end

  // Main sequence.
  initial begin
    int round_end;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.in_byte = '0;
    tx_pace        = PACE_FULL;
    rx_pace        = PACE_FULL;
    min_setting    = MIN_LEN_RST;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: shortest legal frame with no payload, then one payload byte.
    write_min_len(MIN_LEN_RST);
    tx_pace = PACE_RANDOM;
    rx_pace = PACE_RANDOM;
    send_frame(10, NAME_LEN_MIN, FILL_EDGE, 1'b0);
    send_frame(11, NAME_LEN_MIN, FILL_EDGE, 1'b0);

    // Random well-formed frames in rounds, each with its own minimum length.
    hold_pending = 1'b1;
    while (bytes_sent < RANDOM_BYTES) begin
      wait_idle();
      case ($urandom_range(0, 2))
        0:       write_min_len(MIN_LEN_RST);
        1:       write_min_len(17'($urandom_range(11, 40)));
        default: write_min_len(17'($urandom_range(41, 120)));
      endcase
      if ($urandom_range(0, 1)) hold_pending = 1'b1;
      round_end = bytes_sent + 300;
      while (bytes_sent < round_end) random_frame();
    end

    break_stream();
    wait_idle();

    if (tracker.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
hdl/lpad_pkg.sv
hdl/lpad_if.sv
hdl/lpad_adler.sv
hdl/lpad_parser.sv
hdl/lpad_obuf.sv
hdl/length_prefixed_adler32_deframer.sv
verif/deframer_tb_pkg.sv
verif/tb_top.sv
